[src/ccr_pkg.sv]
// Shared types, codes and defaults for the closed Catmull-Rom spline block.
package ccr_pkg;

    localparam int unsigned MAX_POINTS_DEF  = 64;
    localparam int unsigned COORD_WIDTH_DEF = 32;
    localparam int unsigned T_FRAC_BITS_DEF = 16;

    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_EVAL   = 1'b1;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;
    localparam logic [1:0] STAT_SAT   = 2'd3;

    typedef struct packed {
        logic               opcode;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic        [15:0] param_t;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic        [6:0]  points_held;
        logic        [1:0]  status;
    } t_out_item;

endpackage

[src/closed_catmull_rom_spline.sv]
// Top level of the closed uniform Catmull-Rom spline evaluator.
//
// Usage: drive an item on i_in and raise start while busy is low; the item is
// taken on that edge. An append transfer answers on o_valid in the next cycle and
// leaves busy low, so appends can be issued every cycle. An evaluate transfer
// on a non-empty table keeps busy high until its result shows on o_valid, and
// a new item may be started in the cycle that result is shown. The sequence
// runs on the single shared multiplier: t*count, u^2 and u^3 first, then per
// control point one RAM read followed by the x, y, z multiply-accumulates,
// then one rounding step. An evaluate on an empty table answers at once like
// an append. The receiver cannot stall: each result is present for exactly
// one cycle.
module closed_catmull_rom_spline
    import ccr_pkg::*;
#(
    parameter int unsigned MAX_POINTS  = ccr_pkg::MAX_POINTS_DEF,
    parameter int unsigned COORD_WIDTH = ccr_pkg::COORD_WIDTH_DEF,
    parameter int unsigned T_FRAC_BITS = ccr_pkg::T_FRAC_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  ccr_pkg::t_in_item i_in,
    output logic              o_valid,
    output ccr_pkg::t_out_item o_out
);
    localparam int unsigned CW   = COORD_WIDTH;
    localparam int unsigned F    = T_FRAC_BITS;
    localparam int unsigned AW   = $clog2(MAX_POINTS);
    localparam int unsigned CNTW = $clog2(MAX_POINTS + 1);
    // multiplier operand widths: A carries count, u, u2 or a coordinate
    localparam int unsigned MA0  = (CW > F + 1) ? CW : F + 1;
    localparam int unsigned MA   = (MA0 > CNTW + 1) ? MA0 : CNTW + 1;
    localparam int unsigned BW   = F + 4;   // doubled weights stay within about +-2*2^F
    localparam int unsigned PW   = MA + BW;
    localparam int unsigned ACCW = PW + 2;  // four products summed

    localparam logic signed [ACCW-1:0] RND = {{(ACCW-1){1'b0}}, 1'b1} << F;
    localparam logic signed [ACCW-1:0] HI  = {{(ACCW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic signed [ACCW-1:0] LO  = ~HI;

    typedef enum logic [2:0] {
        S_IDLE, S_SEG, S_U2, S_U3, S_RD, S_X, S_Y, S_Z
    } t_state;
    localparam t_state S_LAST = S_Z;

    t_state               r_state;
    logic [CNTW-1:0]      r_count;
    logic [F-1:0]         r_t;
    logic [CNTW-1:0]      r_seg;
    logic [F-1:0]         r_u, r_u2, r_u3;
    logic [AW-1:0]        r_idx;
    logic [1:0]           r_k;
    logic signed [BW-1:0] r_w;
    logic signed [ACCW-1:0] r_acc_x, r_acc_y, r_acc_z;
    logic                 r_fin;

    logic [3*CW-1:0]      ram_rdata;
    logic                 ram_we;
    logic [3*CW-1:0]      ram_wdata;

    logic signed [MA-1:0] mul_a;
    logic signed [BW-1:0] mul_b;
    logic signed [PW-1:0] mul_p;
    logic signed [BW-1:0] w_sel;
    logic signed [BW-1:0] su, su2, su3;
    logic [CNTW-1:0]      idx_inc;
    logic [CW:0]          fx, fy, fz;

    // Append writes straight into the next free entry.
    assign ram_we    = (r_state == S_IDLE) && !r_fin && start
                       && (i_in.opcode == OP_APPEND)
                       && (r_count < CNTW'(MAX_POINTS));
    assign ram_wdata = {CW'($unsigned(i_in.point_x)), CW'($unsigned(i_in.point_y)),
                        CW'($unsigned(i_in.point_z))};

    ccr_ram #(.WIDTH(3 * CW), .DEPTH(MAX_POINTS)) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (AW'(r_count)),
        .i_wdata (ram_wdata),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    // Doubled Catmull-Rom weights, built from shifts and adds only.
    assign su  = BW'($signed({1'b0, r_u}));
    assign su2 = BW'($signed({1'b0, r_u2}));
    assign su3 = BW'($signed({1'b0, r_u3}));

    always_comb begin
        unique case (r_k)
            2'd0: w_sel = -su3 + (su2 <<< 1) - su;
            2'd1: w_sel = (su3 <<< 1) + su3 - (su2 <<< 2) - su2
                          + (BW'(1) <<< (F + 1));
            2'd2: w_sel = -((su3 <<< 1) + su3) + (su2 <<< 2) + su;
            default: w_sel = su3 - su2;
        endcase
    end

    // The one shared multiplier; its operands follow the sequencer.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_SEG: begin
                mul_a = MA'($signed({1'b0, r_count}));
                mul_b = BW'($signed({1'b0, r_t}));
            end
            S_U2: begin
                mul_a = MA'($signed({1'b0, r_u}));
                mul_b = BW'($signed({1'b0, r_u}));
            end
            S_U3: begin
                mul_a = MA'($signed({1'b0, r_u2}));
                mul_b = BW'($signed({1'b0, r_u}));
            end
            S_X: begin
                mul_a = MA'($signed(ram_rdata[3*CW-1:2*CW]));
                mul_b = r_w;
            end
            S_Y: begin
                mul_a = MA'($signed(ram_rdata[2*CW-1:CW]));
                mul_b = r_w;
            end
            S_Z: begin
                mul_a = MA'($signed(ram_rdata[CW-1:0]));
                mul_b = r_w;
            end
            default: ;
        endcase
        mul_p = PW'(mul_a) * PW'(mul_b);
    end

    // Next neighbour index; it wraps modulo the point count where it is used.
    assign idx_inc = CNTW'(r_idx) + CNTW'(1);

    // Round half up at 2^-(F+1), then clamp to the coordinate range.
    function automatic logic [CW:0] f_round_sat(input logic signed [ACCW-1:0] acc);
        logic signed [ACCW-1:0] q;
        q = (acc + RND) >>> (F + 1);
        if (q > HI) begin
            return {1'b1, HI[CW-1:0]};
        end else if (q < LO) begin
            return {1'b1, LO[CW-1:0]};
        end
        return {1'b0, q[CW-1:0]};
    endfunction

    assign fx = f_round_sat(r_acc_x);
    assign fy = f_round_sat(r_acc_y);
    assign fz = f_round_sat(r_acc_z);

    assign busy = (r_state != S_IDLE) || r_fin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_fin   <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            r_fin   <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (r_fin) begin
                        // last multiply-accumulate done: publish the point
                        o_valid           <= 1'b1;
                        o_out.out_x       <= 32'(fx[CW-1:0]);
                        o_out.out_y       <= 32'(fy[CW-1:0]);
                        o_out.out_z       <= 32'(fz[CW-1:0]);
                        o_out.points_held <= 7'(r_count);
                        o_out.status      <= (fx[CW] || fy[CW] || fz[CW]) ? STAT_SAT
                                                                         : STAT_OK;
                    end else if (start) begin
                        o_out.out_x <= '0;
                        o_out.out_y <= '0;
                        o_out.out_z <= '0;
                        if (i_in.opcode == OP_APPEND) begin
                            o_valid <= 1'b1;
                            if (r_count < CNTW'(MAX_POINTS)) begin
                                r_count           <= r_count + CNTW'(1);
                                o_out.points_held <= 7'(r_count + CNTW'(1));
                                o_out.status      <= STAT_OK;
                            end else begin
                                o_out.points_held <= 7'(r_count);
                                o_out.status      <= STAT_FULL;
                            end
                        end else if (r_count == '0) begin
                            o_valid           <= 1'b1;
                            o_out.points_held <= 7'(r_count);
                            o_out.status      <= STAT_EMPTY;
                        end else begin
                            r_t     <= F'(i_in.param_t);
                            r_k     <= 2'd0;
                            r_acc_x <= '0;
                            r_acc_y <= '0;
                            r_acc_z <= '0;
                            r_state <= S_SEG;
                        end
                    end
                end
                S_SEG: begin
                    r_seg   <= mul_p[F +: CNTW];
                    r_u     <= mul_p[F-1:0];
                    r_state <= S_U2;
                end
                S_U2: begin
                    r_u2    <= mul_p[F +: F];
                    r_state <= S_U3;
                end
                S_U3: begin
                    r_u3    <= mul_p[F +: F];
                    // first neighbour is the point before the segment start
                    r_idx   <= (r_seg == '0) ? AW'(r_count - CNTW'(1))
                                             : AW'(r_seg - CNTW'(1));
                    r_state <= S_RD;
                end
                S_RD: begin
                    r_w     <= w_sel;
                    r_state <= S_X;
                end
                S_X: begin
                    r_acc_x <= r_acc_x + ACCW'(mul_p);
                    r_state <= S_Y;
                end
                S_Y: begin
                    r_acc_y <= r_acc_y + ACCW'(mul_p);
                    r_state <= S_Z;
                end
                S_LAST: begin
                    r_acc_z <= r_acc_z + ACCW'(mul_p);
                    if (r_k == 2'd3) begin
                        r_fin   <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_k     <= r_k + 2'd1;
                        r_idx   <= (idx_inc == r_count) ? '0 : AW'(idx_inc);
                        r_state <= S_RD;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

[src/ccr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module ccr_ram #(
    parameter int unsigned WIDTH = 96,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[src/ccr_checker.sv]
// Port-level assertions for the spline block, bound to the top level.
module ccr_checker
    import ccr_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input ccr_pkg::t_in_item i_in,
    input logic              o_valid,
    input ccr_pkg::t_out_item o_out
);
    // empty and full results carry zero coordinates
    a_flag_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_out.status == STAT_EMPTY || o_out.status == STAT_FULL)
        |-> (o_out.out_x == '0 && o_out.out_y == '0 && o_out.out_z == '0))
        else $error("flagged result with non-zero coordinates");

    a_empty_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out.status == STAT_EMPTY |-> o_out.points_held == '0)
        else $error("empty flag with points held");

    a_append_ans: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_in.opcode == OP_APPEND |=> o_valid && !busy)
        else $error("append transfer not answered next cycle");

    a_busy_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> !o_valid)
        else $error("result shown as evaluation starts");
endmodule

bind closed_catmull_rom_spline ccr_checker u_ccr_checker (.*);
